// ===== hdl/u8sd_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int unsigned PEND_DEPTH = 5;
  localparam int unsigned SEQ_MAX    = 6;

  localparam logic [31:0] REPL_RESET = 32'd65533;

  localparam logic [7:0] MASK_FE = 8'hFE;
  localparam logic [7:0] MASK_FC = 8'hFC;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_80 = 8'h80;
  localparam logic [7:0] LEAD6   = 8'hFC;
  localparam logic [7:0] LEAD5   = 8'hF8;
  localparam logic [7:0] LEAD4   = 8'hF0;
  localparam logic [7:0] LEAD3   = 8'hE0;
  localparam logic [7:0] LEAD2   = 8'hC0;
  localparam logic [7:0] ASCII_M = 8'h7F;
  localparam logic [7:0] CONT_M  = 8'h3F;

  typedef logic [2:0] cnt_t;
  typedef logic [PEND_DEPTH-1:0][7:0] pend_t;
  typedef logic [SEQ_MAX-1:0][7:0] seq_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic load_acc;  // accepted byte yields a result now
    logic replay;    // emit one buffered result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_result;  // current input byte would give one result
    logic acc_replay;  // current input byte ends the string with bytes left over
    logic rep_last;    // current replay step empties the buffer
  } stat_t;

  // Sequence length from a lead byte; zero when the byte cannot start a sequence.
  function automatic cnt_t lead_length(input logic [7:0] b);
    cnt_t len;
    if ((b & MASK_FE) == LEAD6) begin
      len = 3'd6;
    end else if ((b & MASK_FC) == LEAD5) begin
      len = 3'd5;
    end else if ((b & MASK_F8) == LEAD4) begin
      len = 3'd4;
    end else if ((b & MASK_F0) == LEAD3) begin
      len = 3'd3;
    end else if ((b & MASK_E0) == LEAD2) begin
      len = 3'd2;
    end else if ((b & MASK_80) == 8'h00) begin
      len = 3'd1;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input cnt_t len);
    logic [7:0] m;
    case (len)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Builds a code point from the first len bytes of a sequence.
  function automatic logic [31:0] assemble(input seq_t s, input cnt_t len);
    logic [31:0] v;
    v = {24'd0, s[0] & lead_mask(len)};
    for (int i = 1; i < SEQ_MAX; i++) begin
      if (3'(i) < len) begin
        v = {v[25:0], s[i][5:0] & CONT_M[5:0]};
      end
    end
    return v;
  endfunction

endpackage

// ===== hdl/u8sd_dpath.sv =====
// Datapath: pending byte buffer, sequence assembly, replacement register and result register.
module u8sd_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  u8sd_pkg::cmd_t  cmd,
  output u8sd_pkg::stat_t sts,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_string,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  output logic [31:0]     out_code_point,
  output logic            out_substituted,
  output logic            out_run_last
);
  import u8sd_pkg::*;

  pend_t       pend_r, pend_nxt;
  cnt_t        cnt_r, cnt_nxt;
  cnt_t        exp_r, exp_nxt;
  logic [31:0] repl_r;
  logic [31:0] cp_r, cp_nxt;
  logic        sub_r, sub_nxt;
  logic        last_r, last_nxt;

  cnt_t        in_len;
  seq_t        acc_seq;
  logic [31:0] acc_cp;
  logic        acc_sub;
  logic        acc_res;
  logic        acc_wr;
  cnt_t        acc_cnt;
  cnt_t        acc_exp;
  logic        acc_rpl;

  cnt_t        rep_len;
  cnt_t        rep_take;
  logic [31:0] rep_cp;
  logic        rep_sub;
  cnt_t        rep_cnt;
  logic        rep_lst;

  // Outcome of taking the byte on the input.
  always_comb begin
    in_len  = lead_length(in_byte);
    for (int j = 0; j < SEQ_MAX; j++) begin
      if (cnt_r == 3'(j)) begin
        acc_seq[j] = in_byte;
      end else if (j < PEND_DEPTH) begin
        acc_seq[j] = pend_r[j];
      end else begin
        acc_seq[j] = 8'h00;
      end
    end
    acc_cp  = repl_r;
    acc_sub = 1'b0;
    acc_res = 1'b0;
    acc_wr  = 1'b0;
    acc_cnt = cnt_r;
    acc_exp = exp_r;
    if (cnt_r == 3'd0) begin
      if (in_len == 3'd0) begin
        acc_res = 1'b1;
        acc_sub = 1'b1;
      end else if (in_len == 3'd1) begin
        acc_res = 1'b1;
        acc_cp  = {24'd0, in_byte & ASCII_M};
      end else begin
        acc_wr  = 1'b1;
        acc_cnt = 3'd1;
        acc_exp = in_len;
      end
    end else if (cnt_r + 3'd1 >= exp_r) begin
      acc_res = 1'b1;
      acc_cp  = assemble(acc_seq, exp_r);
      acc_cnt = 3'd0;
      acc_exp = 3'd0;
    end else if (cnt_r < 3'(PEND_DEPTH)) begin
      acc_wr  = 1'b1;
      acc_cnt = cnt_r + 3'd1;
    end
    acc_rpl = in_end_of_string && (acc_cnt != 3'd0);
  end

  // One result from the head of the buffer while the string end is drained.
  always_comb begin
    rep_len = lead_length(pend_r[0]);
    if (rep_len == 3'd1) begin
      rep_cp   = {24'd0, pend_r[0] & ASCII_M};
      rep_sub  = 1'b0;
      rep_take = 3'd1;
    end else if (rep_len >= 3'd2 && rep_len <= cnt_r) begin
      rep_cp   = assemble({8'h00, pend_r}, rep_len);
      rep_sub  = 1'b0;
      rep_take = rep_len;
    end else begin
      rep_cp   = repl_r;
      rep_sub  = 1'b1;
      rep_take = 3'd1;
    end
    rep_cnt = cnt_r - rep_take;
    rep_lst = (rep_cnt == 3'd0);
  end

  assign sts = '{acc_result: acc_res, acc_replay: acc_rpl, rep_last: rep_lst};

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    cp_nxt   = cp_r;
    sub_nxt  = sub_r;
    last_nxt = last_r;
    if (cmd.accept) begin
      if (acc_wr) begin
        pend_nxt[cnt_r] = in_byte;
      end
      cnt_nxt = acc_cnt;
      exp_nxt = acc_exp;
    end else if (cmd.replay) begin
      // Drop the consumed bytes so the next sequence starts at the head.
      for (int j = 0; j < PEND_DEPTH; j++) begin
        for (int k = 1; k < PEND_DEPTH; k++) begin
          if (rep_take == 3'(k) && j + k < PEND_DEPTH) begin
            pend_nxt[j] = pend_r[j + k];
          end
        end
      end
      cnt_nxt = rep_cnt;
      if (rep_cnt == 3'd0) begin
        exp_nxt = 3'd0;
      end
    end
    if (cmd.load_acc) begin
      cp_nxt   = acc_cp;
      sub_nxt  = acc_sub;
      last_nxt = 1'b1;
    end else if (cmd.replay) begin
      cp_nxt   = rep_cp;
      sub_nxt  = rep_sub;
      last_nxt = rep_lst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      exp_r  <= 3'd0;
      repl_r <= REPL_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      if (cfg_wr_en) begin
        repl_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    cp_r   <= cp_nxt;
    sub_r  <= sub_nxt;
    last_r <= last_nxt;
  end

  assign out_code_point  = cp_r;
  assign out_substituted = sub_r;
  assign out_run_last    = last_r;

endmodule

// ===== hdl/u8sd_ctrl.sv =====
// Controller: handshakes, result register valid and the end-of-string replay state.
module u8sd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  u8sd_pkg::stat_t sts,
  output u8sd_pkg::cmd_t  cmd
);
  import u8sd_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPLAY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_REPLAY) || !out_free;

  always_comb begin
    cmd.accept   = in_valid && !in_stall;
    cmd.load_acc = cmd.accept && sts.acc_result;
    cmd.replay   = (state_r == ST_REPLAY) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = cmd.load_acc || cmd.replay;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.acc_replay) begin
          state_nxt = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (cmd.replay && sts.rep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(sts.acc_result && sts.acc_replay))
    else $error("byte both completes a result and starts a replay");

  a_enter_replay: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.acc_replay |=> state_r == ST_REPLAY)
    else $error("string end with pending bytes did not start a replay");

  a_replay_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.replay |=> out_valid_r)
    else $error("replay step did not present a result");

  a_replay_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.replay && sts.rep_last |=> state_r == ST_IDLE && !cmd.replay)
    else $error("replay continued past the last buffered byte");

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder (one to six byte form): top level joining controller and datapath.
//
// Bytes arrive on the in_ channel, one per transfer, with in_end_of_string on the
// last byte of a string. Code points leave on the out_ channel: out_code_point,
// out_substituted for a replacement, and out_run_last on the last result that a
// byte causes. The replacement code is written through cfg_wr_en / cfg_wr_data.
// A result sits in the output register in the cycle after the byte that completes it,
// and a new byte is taken in every cycle while that register is empty or draining and
// no replay runs, so the sustained rate is one byte per cycle. Lead and middle bytes give
// no result unless they end a string. When a string ends inside a sequence, the buffered
// bytes are drained from a five-byte shift buffer as one to five results, one per cycle
// while out_stall is low, and the input is stalled meanwhile. While out_stall is high the
// result holds, and the input stalls for as long as a result waits in the register.
// Reset empties the buffer, clears out_valid and sets the replacement to 0xFFFD.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic        out_substituted,
  output logic        out_run_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import u8sd_pkg::*;

  cmd_t  cmd;
  stat_t sts;

  u8sd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  u8sd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_code_point   (out_code_point),
    .out_substituted  (out_substituted),
    .out_run_last     (out_run_last)
  );

endmodule

// ===== sim/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder with a queue-fed driver and a monitor.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
  import u8sd_pkg::*;

  typedef struct packed {
    logic [31:0] code_point;
    logic        substituted;
    logic        run_last;
  } result_t;

  typedef struct {
    logic [7:0]  data;
    logic        eos;
    int unsigned gap;
    bit          hold;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_code_point;
  logic        out_substituted;
  logic        out_run_last;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;

  // Decoder model state.
  logic [31:0] repl_code = REPL_RESET;
  logic [7:0]  pend_buf [6];
  int unsigned pend_cnt = 0;
  int unsigned need_len = 0;

  item_t       byte_queue [$];
  result_t     cp_expected [$];
  item_t       tx_item;
  result_t     seen_result;
  int unsigned tx_wait = 0;
  int unsigned stall_left = 0;
  bit          byte_taken = 1'b0;
  bit          result_taken = 1'b0;
  bit          quiet = 1'b0;
  int unsigned mismatch_count = 0;

  utf8_stream_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_substituted  (out_substituted),
    .out_run_last     (out_run_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned seq_len_of(logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      8'b111110??: return 5;
      8'b1111110?: return 6;
      default:     return 0;
    endcase
  endfunction

  // Joins len bytes of pend_buf from start: lead payload, then six bits per byte.
  function automatic logic [31:0] pack_seq(int unsigned start, int unsigned len);
    logic [31:0] v;
    logic [7:0]  m;
    m = (len == 1) ? 8'h7F : (8'hFF >> (len + 1));
    v = {24'd0, pend_buf[start] & m};
    for (int unsigned i = 1; i < len; i++) begin
      v = {v[25:0], pend_buf[start + i][5:0]};
    end
    return v;
  endfunction

  task automatic decode_byte(logic [7:0] b, logic eos);
    result_t     batch [$];
    int unsigned len;
    int unsigned i;
    if (pend_cnt == 0) begin
      len = seq_len_of(b);
      if (len == 0) begin
        batch.push_back('{code_point: repl_code, substituted: 1'b1, run_last: 1'b0});
      end else if (len == 1) begin
        batch.push_back('{code_point: {25'd0, b[6:0]}, substituted: 1'b0, run_last: 1'b0});
      end else begin
        pend_buf[0] = b;
        pend_cnt = 1;
        need_len = len;
      end
    end else if (pend_cnt + 1 >= need_len) begin
      pend_buf[pend_cnt] = b;
      batch.push_back('{code_point: pack_seq(0, pend_cnt + 1), substituted: 1'b0,
                        run_last: 1'b0});
      pend_cnt = 0;
      need_len = 0;
    end else begin
      pend_buf[pend_cnt] = b;
      pend_cnt++;
    end
    // A string that ends inside a sequence replays the buffered bytes as a fresh string.
    if (eos && pend_cnt > 0) begin
      i = 0;
      while (i < pend_cnt) begin
        len = seq_len_of(pend_buf[i]);
        if (len >= 1 && len <= pend_cnt - i) begin
          batch.push_back('{code_point: pack_seq(i, len), substituted: 1'b0, run_last: 1'b0});
          i += len;
        end else begin
          batch.push_back('{code_point: repl_code, substituted: 1'b1, run_last: 1'b0});
          i++;
        end
      end
      pend_cnt = 0;
      need_len = 0;
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].run_last = 1'b1;
    end
    foreach (batch[k]) begin
      cp_expected.push_back(batch[k]);
    end
  endtask

  function automatic int unsigned draw_gap();
    if (quiet || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic push_item(logic [7:0] b, logic eos, bit hold);
    item_t it;
    it.data = b;
    it.eos  = eos;
    it.gap  = draw_gap();
    it.hold = hold;
    byte_queue.push_back(it);
  endtask

  // Mostly well-formed sequences with random payload, some truncated or corrupted,
  // plus raw noise bytes. The middle item waits for all results to drain first.
  task automatic add_random(int unsigned n);
    int unsigned made;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  b;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_item(8'($urandom), $urandom_range(0, 7) == 0, made == n / 2);
        made++;
      end else begin
        len = $urandom_range(1, 6);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len;
        for (int unsigned k = 0; k < cut; k++) begin
          if (k == 0) begin
            b = (len == 1) ? {1'b0, 7'($urandom)}
                           : ((8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1))));
          end else if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom);
          end else begin
            b = {2'b10, 6'($urandom)};
          end
          push_item(b, (k == cut - 1) && (cut < len || $urandom_range(0, 7) == 0),
                    made == n / 2);
          made++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || cp_expected.size() != 0) begin
      @(posedge clk);
    end
    // Leaves room for a replay burst that is still draining.
    repeat (8) @(posedge clk);
  endtask

  task automatic set_replacement(logic [31:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Sender: presents the next byte after its drawn gap once the previous transfer is done.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (byte_queue.size() == 0 || (byte_queue[0].hold && cp_expected.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (tx_wait < byte_queue[0].gap) begin
        tx_wait++;
        in_valid <= 1'b0;
      end else begin
        tx_item = byte_queue.pop_front();
        tx_wait = 0;
        in_valid         <= 1'b1;
        in_byte          <= tx_item.data;
        in_end_of_string <= tx_item.eos;
      end
    end
  end

  // Receiver: raises out_stall for a drawn gap after each result transfer.
  always @(negedge clk) begin
    if (result_taken) begin
      stall_left = draw_gap();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    byte_taken   = 1'b0;
    result_taken = 1'b0;
    if (rst_n) begin
      if (cfg_wr_en) begin
        repl_code = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        result_taken = 1'b1;
        if (cp_expected.size() == 0) begin
          $display("%0t: unexpected result, code_point %h substituted %b run_last %b",
                   $time, out_code_point, out_substituted, out_run_last);
          mismatch_count++;
        end else begin
          seen_result = cp_expected.pop_front();
          if (out_code_point !== seen_result.code_point) begin
            $display("%0t: code_point expected %h actual %h",
                     $time, seen_result.code_point, out_code_point);
            mismatch_count++;
          end
          if (out_substituted !== seen_result.substituted) begin
            $display("%0t: substituted expected %b actual %b",
                     $time, seen_result.substituted, out_substituted);
            mismatch_count++;
          end
          if (out_run_last !== seen_result.run_last) begin
            $display("%0t: run_last expected %b actual %b",
                     $time, seen_result.run_last, out_run_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        decode_byte(in_byte, in_end_of_string);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ASCII extremes, bad leads, an unchecked continuation, the largest
    // six-byte code, a truncation that gives five results, and mixed replays.
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h80, 1'b0, 1'b0);
    push_item(8'hBF, 1'b0, 1'b0);
    push_item(8'hFE, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'hC3, 1'b0, 1'b0);
    push_item(8'h41, 1'b0, 1'b0);
    push_item(8'hFD, 1'b0, 1'b0);
    repeat (4) push_item(8'hBF, 1'b0, 1'b0);
    push_item(8'hBF, 1'b1, 1'b0);
    push_item(8'hFC, 1'b0, 1'b0);
    repeat (3) push_item(8'h80, 1'b0, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'hF8, 1'b0, 1'b0);
    push_item(8'h41, 1'b0, 1'b0);
    push_item(8'hE2, 1'b0, 1'b0);
    push_item(8'h82, 1'b1, 1'b0);
    push_item(8'hC5, 1'b1, 1'b0);
    wait_idle();

    set_replacement(32'h0000_0000);
    add_random(24);
    wait_idle();

    quiet = 1'b1;
    set_replacement(32'hFFFF_FFFF);
    add_random(24);
    wait_idle();

    quiet = 1'b0;
    set_replacement($urandom);
    add_random(24);
    wait_idle();

    set_replacement($urandom_range(0, 32'h0010_FFFF));
    add_random(24);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && cp_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/u8sd_pkg.sv
hdl/u8sd_dpath.sv
hdl/u8sd_ctrl.sv
hdl/utf8_stream_decoder.sv
sim/utf8_stream_decoder_tb.sv
